FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the keyframe sampler checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off during reset
`define KVS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvs check failed");

// next-cycle implication, switched off during reset
`define KVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvs check failed");

// same-cycle implication that stays live across reset
`define KVS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("kvs check failed");

`endif

FILE: sv/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg
// types and constants shared by the keyframe vector sampler
// ----------------------------------------------------------------------------
`default_nettype none

package kvs_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int KC_W      = 5;
  localparam int TIME_W    = 16;
  localparam int COMP_W    = 32;
  localparam int FRAC_W    = 17;
  localparam int DIV_STEPS = 17;
  localparam int CNT_W     = 5;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [3:0]               slot;
    logic [TIME_W-1:0]        key_time;
    logic signed [COMP_W-1:0] key_x;
    logic signed [COMP_W-1:0] key_y;
    logic signed [COMP_W-1:0] key_z;
    logic [TIME_W-1:0]        sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_DIV,
    S_RDLO,
    S_RDHI,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic first_chk;
    logic scan;
    logic div_step;
    logic v_hi;
    logic cap_v0;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first_hit;
    logic bracket;
    logic at_last;
    logic dt_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/kvs_ctrl.sv
// ----------------------------------------------------------------------------
// kvs_ctrl
// sequencer for key search, fraction division and blend
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_action,
  output logic                  in_ready,
  input  wire kvs_pkg::status_t status,
  output kvs_pkg::cmd_t         cmd
);

  kvs_pkg::state_t state;
  kvs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kvs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == kvs_pkg::ACT_SAMPLE) begin
            cmd.start  = 1'b1;
            state_next = kvs_pkg::S_FIRST;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      kvs_pkg::S_FIRST: begin
        cmd.first_chk = 1'b1;
        state_next    = status.first_hit ? kvs_pkg::S_RDLO : kvs_pkg::S_SCAN;
      end
      kvs_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.bracket) begin
          state_next = status.dt_zero ? kvs_pkg::S_RDLO : kvs_pkg::S_DIV;
        end else if (status.at_last) begin
          state_next = kvs_pkg::S_RDLO;
        end
      end
      kvs_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = kvs_pkg::S_RDLO;
        end
      end
      kvs_pkg::S_RDLO: begin
        state_next = kvs_pkg::S_RDHI;
      end
      kvs_pkg::S_RDHI: begin
        cmd.v_hi   = 1'b1;
        cmd.cap_v0 = 1'b1;
        state_next = kvs_pkg::S_MUL;
      end
      kvs_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = kvs_pkg::S_OUT;
      end
      kvs_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = kvs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kvs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/kvs_dp.sv
// ----------------------------------------------------------------------------
// kvs_dp
// key tables, search registers, fraction divider and blend multipliers
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire kvs_pkg::in_item_t         in_data,
  input  wire logic                      cfg_we,
  input  wire logic [kvs_pkg::KC_W-1:0]  cfg_data,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output kvs_pkg::out_item_t             out_data,
  input  wire kvs_pkg::cmd_t             cmd,
  output kvs_pkg::status_t               status
);

  localparam int IW = kvs_pkg::IDX_W;
  localparam int TW = kvs_pkg::TIME_W;
  localparam int CW = kvs_pkg::COMP_W;
  localparam int FW = kvs_pkg::FRAC_W;
  localparam int PW = CW + 1 + FW + 1;

  typedef logic [2:0][CW-1:0] vec_t;

  // key tables
  logic [TW-1:0] time_mem [kvs_pkg::MAX_KEYS];
  vec_t          vec_mem  [kvs_pkg::MAX_KEYS];

  logic [kvs_pkg::KC_W-1:0]  key_count;
  logic [TW-1:0]             samp_t;
  logic [IW-1:0]             last_idx;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             lo;
  logic [IW-1:0]             hi;
  logic [TW-1:0]             t_prev;
  logic [TW-1:0]             t_rd;
  vec_t                      v_rd;
  vec_t                      v0;
  logic [TW-1:0]             dt;
  logic [TW:0]               rem;
  logic [FW-1:0]             quo;
  logic [kvs_pkg::CNT_W-1:0] cnt;
  logic signed [PW-1:0]      prod [3];

  logic [IW-1:0]  t_addr;
  logic [IW-1:0]  v_addr;
  logic [IW-1:0]  last_calc;
  logic           advance;
  logic           ge;
  logic [TW:0]    rem_sub;
  vec_t           res;

  // effective last key index from the count register, clamped
  always_comb begin
    if (key_count == '0) begin
      last_calc = '0;
    end else if (key_count > kvs_pkg::KC_W'(kvs_pkg::MAX_KEYS)) begin
      last_calc = IW'(kvs_pkg::MAX_KEYS - 1);
    end else begin
      last_calc = IW'(key_count - 1'b1);
    end
  end

  assign status.first_hit = (last_idx == '0) || (samp_t <= t_rd);
  assign status.bracket   = (t_prev <= samp_t) && (samp_t <= t_rd);
  assign status.at_last   = (IW'(idx + 1'b1) == last_idx);
  assign status.dt_zero   = (t_rd == t_prev);
  assign status.div_done  = (cnt == kvs_pkg::CNT_W'(kvs_pkg::DIV_STEPS - 1));
  assign status.out_free  = !out_valid || out_ready;

  assign advance = cmd.scan && !status.bracket && !status.at_last;

  always_comb begin
    if (cmd.start) begin
      t_addr = '0;
    end else if (advance) begin
      t_addr = IW'(idx + IW'(2));
    end else begin
      t_addr = IW'(idx + 1'b1);
    end
  end

  assign v_addr = cmd.v_hi ? hi : lo;

  // one restoring division step
  assign ge      = (rem >= {1'b0, dt});
  assign rem_sub = ge ? (rem - {1'b0, dt}) : rem;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_mem[in_data.slot] <= in_data.key_time;
      vec_mem[in_data.slot]  <= {in_data.key_x, in_data.key_y, in_data.key_z};
    end
    t_rd <= time_mem[t_addr];
    v_rd <= vec_mem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvs_pkg::KC_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // search and divider registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      samp_t   <= in_data.sample_time;
      last_idx <= last_calc;
      idx      <= '0;
    end
    if (cmd.first_chk) begin
      t_prev <= t_rd;
      lo     <= '0;
      hi     <= '0;
      quo    <= '0;
    end
    if (cmd.scan) begin
      if (status.bracket) begin
        lo  <= idx;
        hi  <= IW'(idx + 1'b1);
        dt  <= t_rd - t_prev;
        rem <= {1'b0, samp_t - t_prev};
        quo <= '0;
        cnt <= '0;
      end else if (status.at_last) begin
        lo  <= last_idx;
        hi  <= last_idx;
        quo <= '0;
      end else begin
        t_prev <= t_rd;
        idx    <= IW'(idx + 1'b1);
      end
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[TW-1:0], 1'b0};
      quo <= {quo[FW-2:0], ge};
      cnt <= kvs_pkg::CNT_W'(cnt + 1'b1);
    end
    if (cmd.cap_v0) begin
      v0 <= v_rd;
    end
  end

  // (v1 - v0) * f per component
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= ($signed({v_rd[c][CW-1], v_rd[c]}) - $signed({v0[c][CW-1], v0[c]}))
                   * $signed({1'b0, quo});
      end
    end
  end

  function automatic logic [CW-1:0] prod_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = p + PW'(32768);
    return r[CW+15:16];
  endfunction

  // round half up, floor shift, add base
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = v0[c] + prod_round(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_x <= res[2];
      out_data.out_y <= res[1];
      out_data.out_z <= res[0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/keyframe_vector_sampler_unit.sv
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_unit
// keyframe table with linear interpolation of a 3-component vector
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready/in_data carries one item per handshake.
//   a load item (action 0) writes time and vector into a table slot in one
//   cycle; in_ready stays high so loads can stream back to back.
//   a sample item (action 1) searches the first key_count keys and returns
//   one item on out_valid/out_ready/out_data.
//   a sample at or before the first key skips the search; otherwise key
//   pairs are scanned in order and the serial fraction divider then forms
//   the 17-bit fraction, one quotient bit a cycle. with no bracketing pair,
//   or with equal times in the bracketing pair, the divider is skipped.
//   one sample is in flight at a time; in_ready is low while it runs.
//   the result sits in an output register, so a stalled receiver does not
//   stop the next item being taken; a finished result only waits if that
//   register is still occupied.
//   cfg_we/cfg_data write key_count; the user must do so only while the
//   block is idle, the block does not enforce it. reset: key_count goes to
//   1, the output register empties; table contents undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_sampler_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // item input
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire kvs_pkg::in_item_t         in_data,
  // result output
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output kvs_pkg::out_item_t             out_data,
  // key_count register write
  input  wire logic                      cfg_we,
  input  wire logic [kvs_pkg::KC_W-1:0]  cfg_data
);

  kvs_pkg::cmd_t    cmd;
  kvs_pkg::status_t status;

  // sequencer: search, divide, blend, hand off
  kvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // tables, divider, multipliers and output register
  kvs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

FILE: sv/kvs_checker.sv
// ----------------------------------------------------------------------------
// kvs_checker
// port-level checks on the keyframe vector sampler
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvs_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire kvs_pkg::in_item_t         in_data,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire kvs_pkg::out_item_t        out_data,
  input wire logic                      cfg_we
);

  logic samp_acc;
  logic load_acc;
  logic out_stall;
  logic cfg_seen;

  assign samp_acc  = in_valid && in_ready && (in_data.action == kvs_pkg::ACT_SAMPLE);
  assign load_acc  = in_valid && in_ready && (in_data.action == kvs_pkg::ACT_LOAD);
  assign out_stall = out_valid && !out_ready;
  assign cfg_seen  = cfg_we;

  `KVS_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid)
  `KVS_ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable(out_data))
  `KVS_ASSERT_NEXT(a_sample_busy, clk, rst, samp_acc, !in_ready)
  `KVS_ASSERT_NEXT(a_load_single, clk, rst, load_acc || cfg_seen, in_ready)
  `KVS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid)

endmodule

bind keyframe_vector_sampler_unit kvs_checker u_kvs_checker (.*);

`default_nettype wire

FILE: verif/keyframe_vector_sampler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_unit_tb
// self-checking bench for the keyframe table and its linear interpolation
// ----------------------------------------------------------------------------
// a short directed table (single key, before the first key, exact key
// times, past the last key, unordered keys, equal key times, key_count of
// zero) is followed by random keyframe sets loaded in time order with
// samples spread over them, plus stray loads and unordered sets. samples
// with no listed result are predicted from a local key table and key_count;
// each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module keyframe_vector_sampler_unit_tb;

  localparam int RANDOM_ITEMS = 1950;
  localparam int SETTLE_CYCLES = 8;    // margin for the last load to finish
  localparam int TAIL_CYCLES = 64;     // beyond the slowest sample latency
  localparam int REPORT_LIMIT = 10;

  // directed table rows
  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    kvs_pkg::in_item_t  item;
    logic [4:0]         count;
    bit                 typed;
    kvs_pkg::out_item_t want;
  } row_t;

  // keyframe vectors used by the directed table
  localparam kvs_pkg::out_item_t VEC_A = '{out_x: 32'h7FFF_FFFF, out_y: 32'h8000_0000,
                                           out_z: 32'h0000_0000};
  localparam kvs_pkg::out_item_t VEC_B = '{out_x: 32'h8000_0000, out_y: 32'h7FFF_FFFF,
                                           out_z: 32'hFFFF_0000};
  localparam kvs_pkg::out_item_t VEC_C = '{out_x: 32'h0001_8000, out_y: 32'hFFFE_8000,
                                           out_z: 32'h0000_0001};
  localparam kvs_pkg::out_item_t VEC_D = '{out_x: 32'h1234_5678, out_y: 32'hEDCB_A988,
                                           out_z: 32'hFFFF_FFFF};
  localparam kvs_pkg::out_item_t VEC_E = '{out_x: 32'hFFFF_FFFF, out_y: 32'h0000_0001,
                                           out_z: 32'h5555_5555};
  localparam kvs_pkg::out_item_t VEC_F = '{out_x: 32'hAAAA_AAAA, out_y: 32'h7FFF_0000,
                                           out_z: 32'h8000_0001};

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  kvs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  kvs_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_data = '0;

  // local copy of the block state
  logic [15:0] key_time_mem [kvs_pkg::MAX_KEYS];
  logic [31:0] key_x_mem    [kvs_pkg::MAX_KEYS];
  logic [31:0] key_y_mem    [kvs_pkg::MAX_KEYS];
  logic [31:0] key_z_mem    [kvs_pkg::MAX_KEYS];
  logic [4:0]  keys_in_use;

  kvs_pkg::out_item_t pending_vectors [$];
  row_t               plan [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int samples_sent = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int fails = 0;

  keyframe_vector_sampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // interpolation predictor
  // ---------------------------------------------------------------------------

  // v0 + floor(((v1 - v0) * f + 0.5) / 1.0) in Q16, rounding half up
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input int unsigned f);
    longint v0;
    longint v1;
    longint p;
    logic [63:0] r;
    v0 = longint'($signed(a));
    v1 = longint'($signed(b));
    p  = (v1 - v0) * longint'(f) + 64'sd32768;
    r  = v0 + (p >>> 16);
    return r[31:0];
  endfunction

  function automatic kvs_pkg::out_item_t interpolate_at(input logic [15:0] t);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned f;
    int unsigned dt;
    int unsigned i;
    bit found;
    kvs_pkg::out_item_t r;
    n = keys_in_use;
    if (n == 0) n = 1;
    if (n > kvs_pkg::MAX_KEYS) n = kvs_pkg::MAX_KEYS;
    lo = 0;
    hi = 0;
    f = 0;
    found = 1'b0;
    if (n > 1 && t > key_time_mem[0]) begin
      // first pair in index order that brackets the time
      for (i = 0; i + 1 < n && !found; i++) begin
        if (key_time_mem[i] <= t && t <= key_time_mem[i+1]) begin
          dt = key_time_mem[i+1] - key_time_mem[i];
          lo = i;
          hi = i + 1;
          f = (dt == 0) ? 0 : ((t - key_time_mem[i]) << 16) / dt;
          found = 1'b1;
        end
      end
      // past the last key, or no bracketing pair in unordered keys
      if (!found) begin
        lo = n - 1;
        hi = n - 1;
      end
    end
    r.out_x = blend(key_x_mem[lo], key_x_mem[hi], f);
    r.out_y = blend(key_y_mem[lo], key_y_mem[hi], f);
    r.out_z = blend(key_z_mem[lo], key_z_mem[hi], f);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  // every field random, so unused fields toggle as well
  function automatic kvs_pkg::in_item_t scrambled_item();
    kvs_pkg::in_item_t it;
    it.action      = 1'($urandom_range(1));
    it.slot        = 4'($urandom_range(15));
    it.key_time    = 16'($urandom);
    it.key_x       = $urandom;
    it.key_y       = $urandom;
    it.key_z       = $urandom;
    it.sample_time = 16'($urandom);
    return it;
  endfunction

  function automatic kvs_pkg::in_item_t load_item(input logic [3:0] s,
                                                  input logic [15:0] t,
                                                  input kvs_pkg::out_item_t v);
    kvs_pkg::in_item_t it;
    it = scrambled_item();
    it.action   = kvs_pkg::ACT_LOAD;
    it.slot     = s;
    it.key_time = t;
    it.key_x    = v.out_x;
    it.key_y    = v.out_y;
    it.key_z    = v.out_z;
    return it;
  endfunction

  function automatic kvs_pkg::in_item_t sample_item(input logic [15:0] t);
    kvs_pkg::in_item_t it;
    it = scrambled_item();
    it.action      = kvs_pkg::ACT_SAMPLE;
    it.sample_time = t;
    return it;
  endfunction

  function automatic row_t load_row(input logic [3:0] s, input logic [15:0] t,
                                    input kvs_pkg::out_item_t v);
    row_t r;
    r.kind  = ROW_LOAD;
    r.item  = load_item(s, t, v);
    r.count = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t sample_row(input logic [15:0] t, input bit typed,
                                      input kvs_pkg::out_item_t want);
    row_t r;
    r.kind  = ROW_SAMPLE;
    r.item  = sample_item(t);
    r.count = '0;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [4:0] v);
    row_t r;
    r.kind  = ROW_CFG;
    r.item  = '0;
    r.count = v;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item, hold it until taken, then update the local state;
  // in_valid is left high so a following item can go out without a gap
  task automatic push_item(input kvs_pkg::in_item_t it, input bit typed,
                           input kvs_pkg::out_item_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.action == kvs_pkg::ACT_LOAD) begin
      key_time_mem[it.slot] = it.key_time;
      key_x_mem[it.slot]    = it.key_x;
      key_y_mem[it.slot]    = it.key_y;
      key_z_mem[it.slot]    = it.key_z;
      loads_sent++;
    end else begin
      pending_vectors.push_back(typed ? want : interpolate_at(it.sample_time));
      samples_sent++;
    end
  endtask

  // stop sending until every result is back; at least one edge passes so
  // in_valid is never lowered and raised in the same step
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_vectors.size() != 0);
  endtask

  // key_count is only written with the block idle
  task automatic write_key_count(input logic [4:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    keys_in_use = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random back-pressure and result check
  // ---------------------------------------------------------------------------

  task automatic check_vector(input kvs_pkg::out_item_t got);
    kvs_pkg::out_item_t want;
    bit bad;
    if (pending_vectors.size() == 0) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("unexpected result x=%h y=%h z=%h", got.out_x, got.out_y, got.out_z);
    end else begin
      want = pending_vectors.pop_front();
      results_seen++;
      bad = (got.out_x !== want.out_x) || (got.out_y !== want.out_y) ||
            (got.out_z !== want.out_z);
      if (bad) begin
        fails++;
        if (fails <= REPORT_LIMIT)
          $display("result %0d: want x=%h y=%h z=%h, got x=%h y=%h z=%h",
                   results_seen, want.out_x, want.out_y, want.out_z,
                   got.out_x, got.out_y, got.out_z);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_vector(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int directed_items;
    int n;
    int n_samples;
    int pick;
    int span;
    int base;
    int j;
    int k;
    int lo_b;
    int hi_b;
    logic [4:0]         cfg_v;
    logic [15:0]        times [kvs_pkg::MAX_KEYS];
    logic [15:0]        tv;
    logic [15:0]        st;
    kvs_pkg::out_item_t vec;
    kvs_pkg::in_item_t  it;

    keys_in_use = 5'd1;
    for (k = 0; k < kvs_pkg::MAX_KEYS; k++) begin
      key_time_mem[k] = '0;
      key_x_mem[k] = '0;
      key_y_mem[k] = '0;
      key_z_mem[k] = '0;
    end

    // directed table: four ordered keys, then the corner cases
    plan.push_back(load_row(4'd0, 16'h0100, VEC_A));
    plan.push_back(load_row(4'd1, 16'h0200, VEC_B));
    plan.push_back(load_row(4'd2, 16'h0300, VEC_C));
    plan.push_back(load_row(4'd3, 16'hFFFF, VEC_D));
    plan.push_back(sample_row(16'h0180, 1'b1, VEC_A));   // single key after reset
    plan.push_back(cfg_row(5'd4));
    plan.push_back(sample_row(16'h0000, 1'b1, VEC_A));   // earliest time
    plan.push_back(sample_row(16'h0100, 1'b1, VEC_A));   // at the first key
    plan.push_back(sample_row(16'h0180, 1'b0, '0));      // halfway, full-scale swing
    plan.push_back(sample_row(16'h0200, 1'b1, VEC_B));   // exactly on a key, fraction one
    plan.push_back(sample_row(16'h0201, 1'b0, '0));
    plan.push_back(sample_row(16'h02FF, 1'b0, '0));
    plan.push_back(sample_row(16'hFFFF, 1'b1, VEC_D));   // latest time on the last key
    plan.push_back(sample_row(16'hFFFE, 1'b0, '0));
    plan.push_back(load_row(4'd3, 16'h0250, VEC_E));     // keys now out of order
    plan.push_back(sample_row(16'h0400, 1'b1, VEC_E));   // no bracketing pair
    plan.push_back(sample_row(16'h0280, 1'b0, '0));
    plan.push_back(load_row(4'd15, 16'hFFFF, VEC_F));    // highest slot
    plan.push_back(cfg_row(5'd0));                       // zero count acts as one
    plan.push_back(sample_row(16'hFFFF, 1'b1, VEC_A));
    plan.push_back(cfg_row(5'd2));
    plan.push_back(load_row(4'd1, 16'h0100, VEC_F));     // two keys at the same time
    plan.push_back(sample_row(16'h0100, 1'b1, VEC_A));
    plan.push_back(sample_row(16'h0101, 1'b1, VEC_F));

    // reset once at the start
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_stall_pct = 60;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG)
        write_key_count(plan[r].count);
      else
        push_item(plan[r].item, plan[r].typed, plan[r].want);
    end
    directed_items = items_sent;

    // random keyframe sets, each behind a fresh key_count
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      // idling schedule: sender light / receiver heavy, then swapped, then none
      if (items_sent - directed_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 24;
        recv_stall_pct = 60;
      end else if (items_sent - directed_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 60;
        recv_stall_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      case ($urandom_range(9))
        0:       cfg_v = 5'd0;
        1:       cfg_v = 5'($urandom_range(17, 31));
        2:       cfg_v = 5'd16;
        3:       cfg_v = 5'd1;
        default: cfg_v = 5'($urandom_range(2, 16));
      endcase
      n = (cfg_v == 0) ? 1 : ((cfg_v > kvs_pkg::MAX_KEYS) ? kvs_pkg::MAX_KEYS : cfg_v);
      write_key_count(cfg_v);

      // key times in ascending order, sometimes packed tightly
      span = ($urandom_range(3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 65535);
      base = $urandom_range(0, 65535 - span);
      for (k = 0; k < n; k++) begin
        tv = 16'(base + $urandom_range(0, span));
        j = k;
        while (j > 0 && times[j-1] > tv) begin
          times[j] = times[j-1];
          j--;
        end
        times[j] = tv;
      end
      // now and then an unordered set
      if (n > 1 && $urandom_range(9) == 0) begin
        j = $urandom_range(0, n - 1);
        k = $urandom_range(0, n - 1);
        tv = times[j];
        times[j] = times[k];
        times[k] = tv;
      end

      // every slot in use is loaded before any sample reads it
      for (k = 0; k < n; k++) begin
        vec.out_x = $urandom;
        vec.out_y = $urandom;
        vec.out_z = $urandom;
        if ($urandom_range(4) == 0) begin
          vec.out_x = $urandom_range(0, 511) - 256;
          vec.out_y = $urandom_range(0, 511) - 256;
        end
        push_item(load_item(4'(k), times[k], vec), 1'b0, '0);
      end

      lo_b = (times[0] < times[n-1]) ? times[0] : times[n-1];
      hi_b = (times[0] < times[n-1]) ? times[n-1] : times[0];
      lo_b = (lo_b > 8) ? lo_b - 8 : 0;
      hi_b = (hi_b < 65527) ? hi_b + 8 : 65535;

      n_samples = $urandom_range(4, 30);
      for (j = 0; j < n_samples; j++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // stray load that may break the ordering
          it = scrambled_item();
          it.action = kvs_pkg::ACT_LOAD;
          push_item(it, 1'b0, '0);
        end else begin
          if (pick < 10) drain_results();
          pick = $urandom_range(99);
          if (pick < 15)
            st = times[$urandom_range(0, n - 1)] + 16'($urandom_range(2)) - 16'd1;
          else if (pick < 25)
            st = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else if (pick < 35)
            st = 16'($urandom);
          else
            st = 16'($urandom_range(lo_b, hi_b));
          push_item(sample_item(st), 1'b0, '0);
        end
      end
    end

    // wait for the last results and a quiet tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d samples and %0d key_count writes over three idling mixes",
             loads_sent, samples_sent, cfg_writes);
    $display("checked %0d results, %0d failures", results_seen, fails);
    if (fails == 0 && pending_vectors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
